FILE: design/aes_pkg.sv
// aes_pkg: shared types, s-box and round helpers for the aes-128 block
// depends on nothing
`timescale 1ns / 1ps
package aes_pkg;

	localparam int NUM_ROUNDS = 10;

	localparam logic [7:0] POLY_REDUCE = 8'h1b;

	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	typedef logic [127:0] block_t;

	typedef logic [7:0] sbox_table_t [256];

	localparam sbox_table_t SBOX = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// byte i of the block sits at bits 127-8i down
	function automatic logic [7:0] get_byte(input block_t b, input int i);
		get_byte = b[127 - 8 * i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? POLY_REDUCE : 8'h00);
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t r;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int w = 0; w < 4; w++) begin
				r[127 - 8 * (c * 4 + w) -: 8] = SBOX[get_byte(s, ((c + w) % 4) * 4 + w)];
			end
		end
		sub_shift = r;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t r;
		logic [7:0] a0, a1, a2, a3, all;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, c * 4);
			a1 = get_byte(s, c * 4 + 1);
			a2 = get_byte(s, c * 4 + 2);
			a3 = get_byte(s, c * 4 + 3);
			all = a0 ^ a1 ^ a2 ^ a3;
			r[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
				a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
		end
		mix_columns = r;
	endfunction

	// next round key from previous one and round constant
	function automatic block_t next_key(input block_t k, input logic [7:0] rc);
		logic [31:0] t, w0, w1, w2, w3;
		t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		next_key = {w0, w1, w2, w3};
	endfunction

endpackage

FILE: design/aes_key_sched.sv
// aes_key_sched: registered round-key schedule, recomputed from the key registers
// depends on aes_pkg
`timescale 1ns / 1ps
module aes_key_sched import aes_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  block_t key,
	output block_t round_key [NUM_ROUNDS + 1]
);

	block_t key_q [NUM_ROUNDS + 1];
	block_t zero_key [NUM_ROUNDS + 1];
	logic [7:0] rc [NUM_ROUNDS];

	always_comb begin
		rc[0] = 8'h01;
		for (int i = 1; i < NUM_ROUNDS; i++) rc[i] = xtime(rc[i - 1]);
	end

	// schedule of the all-zero reset key, constant after folding
	always_comb begin
		zero_key[0] = '0;
		for (int i = 1; i <= NUM_ROUNDS; i++) zero_key[i] = next_key(zero_key[i - 1], rc[i - 1]);
	end

	// one expansion step per register; stage i is loaded ahead of data stage i
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NUM_ROUNDS; i++) key_q[i] <= zero_key[i];
		end else begin
			key_q[0] <= key;
			for (int i = 1; i <= NUM_ROUNDS; i++) key_q[i] <= next_key(key_q[i - 1], rc[i - 1]);
		end
	end

	assign round_key = key_q;

endmodule

FILE: design/aes_round.sv
// aes_round: one registered aes round stage with valid and stall
// depends on aes_pkg
`timescale 1ns / 1ps
module aes_round import aes_pkg::*; #(
	parameter bit LAST = 1'b0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  block_t in_state,
	input  block_t rkey,
	output logic   out_valid,
	output block_t out_state
);

	block_t ss;

	always_comb begin
		ss = sub_shift(in_state);
		if (!LAST) ss = mix_columns(ss);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_state <= ss ^ rkey;
	end

endmodule

FILE: design/aes128_block_encrypt.sv
// aes128_block_encrypt: fully unrolled pipelined aes-128 encryption
// depends on aes_pkg, aes_key_sched, aes_round
`timescale 1ns / 1ps
// usage
//  - cfg channel: cfg_index 0 writes key bytes 0..7, index 1 bytes 8..15;
//    other indexes are ignored; cfg_ready is always high
//  - s_axis word: one plaintext block, m_axis word: one ciphertext block
//  - eleven register stages: the initial key add, then one per round; the
//    first is loaded at the accepting edge
//  - throughput one word per cycle unless the receiver stalls or a key is
//    written; the whole pipe advances together
//  - when the receiver stalls the pipe freezes; s_axis_tready is high
//    if the last stage is empty or taken, bar key writes, so bubbles fill
//  - round keys come from an 11-deep registered schedule that is filled
//    ahead of the data; s_axis_tready drops while a key word is offered
//    and in the cycle after, so no word meets a stale round key
//  - the user writes keys only while the pipe is empty; it is not enforced
//  - reset clears the key to zero, loads its schedule and empties the pipe
module aes128_block_encrypt import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,   // register index
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // [63:0] plain_high, [127:64] plain_low
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // [63:0] cipher_high, [127:64] cipher_low
);

	logic [63:0] key_high_q, key_low_q;
	logic        key_new_q;
	block_t      rk [NUM_ROUNDS + 1];
	logic        en;
	logic        v   [NUM_ROUNDS + 1];
	block_t      st  [NUM_ROUNDS + 1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			key_new_q  <= 1'b0;
		end else begin
			key_new_q <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW:  key_low_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	aes_key_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       ({key_high_q, key_low_q}),
		.round_key (rk)
	);

	// whole pipe moves when the output is free or being taken
	assign en            = !v[NUM_ROUNDS] || m_axis_tready;
	// hold input off until the new key has reached the first schedule stage
	assign s_axis_tready = en && !cfg_valid && !key_new_q;

	// stage 0: initial key add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (en) begin
			v[0] <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) st[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ rk[0];
	end

	for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
		aes_round #(.LAST(r == NUM_ROUNDS)) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v[r - 1]),
			.in_state  (st[r - 1]),
			.rkey      (rk[r]),
			.out_valid (v[r]),
			.out_state (st[r])
		);
	end

	assign m_axis_tvalid = v[NUM_ROUNDS];
	assign m_axis_tdata  = {st[NUM_ROUNDS][63:0], st[NUM_ROUNDS][127:64]};

endmodule
